### sv/mbe_pkg.sv
`default_nettype none

package mbe_pkg;

    // Default coordinate format: signed Q4.60 in 64-bit words
    localparam int COORD_WIDTH_DEF = 64;
    localparam int FRAC_BITS_DEF   = 60;

    // Step counter and iteration limit register
    localparam int                    STEP_WIDTH      = 16;
    localparam logic [STEP_WIDTH-1:0] MAX_STEPS_RESET = 16'd5000;

endpackage

`default_nettype wire

### sv/mbe_sq_unit.sv
`default_nettype none

// Forms zr*zr, zi*zi and zr*zi from two magnitudes with one shared
// half-width multiplier, four partial products per result, twelve in all.
module mbe_sq_unit import mbe_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [COORD_WIDTH-1:0]   i_zr_mag,
    input  logic [COORD_WIDTH-1:0]   i_zi_mag,
    output logic                     o_done,
    output logic [2*COORD_WIDTH-1:0] o_sq_re,
    output logic [2*COORD_WIDTH-1:0] o_sq_im,
    output logic [2*COORD_WIDTH-1:0] o_cross
);

    localparam int HW = (COORD_WIDTH + 1) / 2;
    localparam int PW = 2 * HW;
    localparam int AW = 2 * PW;

    // Which product is being built
    typedef enum logic [1:0] {
        PAIR_RR,
        PAIR_II,
        PAIR_RI
    } t_pair;

    // Part bit 1 picks the high half of operand a, bit 0 that of operand b
    localparam logic [1:0] PART_LAST = 2'd3;

    logic          r_busy;
    t_pair         r_pair;
    logic [1:0]    r_part;
    logic          r_pvld;
    t_pair         r_tag_pair;
    logic [1:0]    r_tag_part;
    logic          r_done;
    logic [PW-1:0] r_prod;
    logic [AW-1:0] r_acc_rr;
    logic [AW-1:0] r_acc_ii;
    logic [AW-1:0] r_acc_ri;

    logic [COORD_WIDTH-1:0] op_a;
    logic [COORD_WIDTH-1:0] op_b;
    logic [PW-1:0]          ext_a;
    logic [PW-1:0]          ext_b;
    logic [HW-1:0]          half_a;
    logic [HW-1:0]          half_b;
    logic [AW-1:0]          shifted;
    logic                   last_issue;

    // Pick operands and halves for the current partial product
    always_comb begin
        unique case (r_pair)
            PAIR_RR: begin
                op_a = i_zr_mag;
                op_b = i_zr_mag;
            end
            PAIR_II: begin
                op_a = i_zi_mag;
                op_b = i_zi_mag;
            end
            default: begin
                op_a = i_zr_mag;
                op_b = i_zi_mag;
            end
        endcase
        ext_a  = PW'(op_a);
        ext_b  = PW'(op_b);
        half_a = r_part[1] ? ext_a[PW-1:HW] : ext_a[HW-1:0];
        half_b = r_part[0] ? ext_b[PW-1:HW] : ext_b[HW-1:0];
    end

    assign last_issue = (r_pair == PAIR_RI) && (r_part == PART_LAST);

    // Align the registered partial product to its weight
    always_comb begin
        unique case (r_tag_part)
            2'd0:    shifted = AW'(r_prod);
            2'd3:    shifted = AW'(r_prod) << (2 * HW);
            default: shifted = AW'(r_prod) << HW;
        endcase
    end

    // Sequence control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pvld <= 1'b0;
            r_done <= 1'b0;
            r_pair <= PAIR_RR;
            r_part <= 2'd0;
        end else begin
            r_done <= r_pvld && (r_tag_pair == PAIR_RI) && (r_tag_part == PART_LAST);
            r_pvld <= r_busy;
            if (i_start) begin
                r_busy <= 1'b1;
                r_pair <= PAIR_RR;
                r_part <= 2'd0;
            end else if (r_busy) begin
                r_part <= r_part + 2'd1;
                if (r_part == PART_LAST) begin
                    unique case (r_pair)
                        PAIR_RR: r_pair <= PAIR_II;
                        PAIR_II: r_pair <= PAIR_RI;
                        default: r_pair <= PAIR_RR;
                    endcase
                end
                if (last_issue) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Multiply into a register, then accumulate the registered product in the next cycle
    always_ff @(posedge i_clk) begin
        r_prod     <= PW'(half_a) * PW'(half_b);
        r_tag_pair <= r_pair;
        r_tag_part <= r_part;
        if (i_start) begin
            r_acc_rr <= '0;
            r_acc_ii <= '0;
            r_acc_ri <= '0;
        end else if (r_pvld) begin
            unique case (r_tag_pair)
                PAIR_RR: r_acc_rr <= r_acc_rr + shifted;
                PAIR_II: r_acc_ii <= r_acc_ii + shifted;
                default: r_acc_ri <= r_acc_ri + shifted;
            endcase
        end
    end

    assign o_done  = r_done;
    assign o_sq_re = r_acc_rr[2*COORD_WIDTH-1:0];
    assign o_sq_im = r_acc_ii[2*COORD_WIDTH-1:0];
    assign o_cross = r_acc_ri[2*COORD_WIDTH-1:0];

endmodule

`default_nettype wire

### sv/mandelbrot_escape_time.sv
`default_nettype none

// Channel   Direction  Handshake           Payload
// point     in         i_valid / o_ready   i_c_real, i_c_imag
// count     out        o_valid / i_ready   o_escape_count
// config    in         i_cfg_wr_en         i_cfg_wr_data (max_steps)
//
// One point at a time; each iteration step runs the limit check, the square unit
// (start, twelve partial products on the shared half-width multiplier, accumulate,
// done), the escape test and the update. The count is offered once the escape test
// finds an escape or the limit check stops the point.
// Reset restores max_steps to 5000 and returns the block to idle.
// A waiting result holds o_escape_count and blocks new points until transferred.
module mandelbrot_escape_time import mbe_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [COORD_WIDTH-1:0] i_c_real,
    input  logic signed [COORD_WIDTH-1:0] i_c_imag,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [STEP_WIDTH-1:0]         o_escape_count,
    input  logic                          i_cfg_wr_en,
    input  logic [STEP_WIDTH-1:0]         i_cfg_wr_data
);

    localparam int W  = COORD_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int MW = (F + 2 > W) ? F + 2 : W;
    localparam int CW = (2 * W + 1 > 2 * F + 3) ? 2 * W + 1 : 2 * F + 3;
    localparam logic [CW-1:0] FOUR = CW'(1) << (2 * F + 2);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LIMIT,
        S_MUL,
        S_TEST,
        S_UPD,
        S_DONE
    } t_state;

    t_state                r_state,     n_state;
    logic [STEP_WIDTH-1:0] r_n,         n_n;
    logic [STEP_WIDTH-1:0] r_max_steps, n_max_steps;
    logic                  r_sq_start,  n_sq_start;
    logic                  r_cr_neg,    n_cr_neg;
    logic [W-1:0]          r_cr_mag,    n_cr_mag;
    logic                  r_ci_neg,    n_ci_neg;
    logic [W-1:0]          r_ci_mag,    n_ci_mag;
    logic                  r_zr_neg,    n_zr_neg;
    logic [W-1:0]          r_zr_mag,    n_zr_mag;
    logic                  r_zi_neg,    n_zi_neg;
    logic [W-1:0]          r_zi_mag,    n_zi_mag;
    logic                  r_tr_neg,    n_tr_neg;
    logic [MW-1:0]         r_tr_mag,    n_tr_mag;
    logic                  r_ti_neg,    n_ti_neg;
    logic [MW-1:0]         r_ti_mag,    n_ti_mag;

    logic             sq_done;
    logic [2*W-1:0]   sq_re;
    logic [2*W-1:0]   sq_im;
    logic [2*W-1:0]   sq_cross;
    logic [CW-1:0]    mag_sum;
    logic             escape;
    logic             re_ge;
    logic [2*W-1:0]   diff;
    logic [CW-1:0]    diff_ext;
    logic [CW-1:0]    cross_ext;
    logic [W-1:0]     cr_mag_in;
    logic [W-1:0]     ci_mag_in;
    logic [W:0]       zr_next;
    logic [W:0]       zi_next;

    // Signed add of sign-magnitude values, clamped to the coordinate range
    function automatic logic [W:0] f_sat_add(
        input logic          a_neg,
        input logic [MW-1:0] a_mag,
        input logic          b_neg,
        input logic [W-1:0]  b_mag
    );
        logic [MW:0] ea;
        logic [MW:0] eb;
        logic [MW:0] s;
        logic [MW:0] top;
        logic        s_neg;
        ea  = (MW+1)'(a_mag);
        eb  = (MW+1)'(b_mag);
        top = (MW+1)'(1) << (W - 1);
        if (a_neg == b_neg) begin
            s     = ea + eb;
            s_neg = a_neg;
        end else if (ea >= eb) begin
            s     = ea - eb;
            s_neg = a_neg;
        end else begin
            s     = eb - ea;
            s_neg = b_neg;
        end
        if (s_neg) begin
            if (s > top) s = top;
        end else if (s > top - (MW+1)'(1)) begin
            s = top - (MW+1)'(1);
        end
        return {s_neg, s[W-1:0]};
    endfunction

    mbe_sq_unit #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_sq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_sq_start),
        .i_zr_mag (r_zr_mag),
        .i_zi_mag (r_zi_mag),
        .o_done   (sq_done),
        .o_sq_re  (sq_re),
        .o_sq_im  (sq_im),
        .o_cross  (sq_cross)
    );

    // Split the incoming point into sign and magnitude
    assign cr_mag_in = i_c_real[W-1] ? (~$unsigned(i_c_real) + W'(1)) : $unsigned(i_c_real);
    assign ci_mag_in = i_c_imag[W-1] ? (~$unsigned(i_c_imag) + W'(1)) : $unsigned(i_c_imag);

    // Escape test and cut back of the new real and imaginary parts
    always_comb begin
        mag_sum   = CW'(sq_re) + CW'(sq_im);
        escape    = (mag_sum >= FOUR);
        re_ge     = (sq_re >= sq_im);
        diff      = re_ge ? (sq_re - sq_im) : (sq_im - sq_re);
        diff_ext  = CW'(diff);
        cross_ext = CW'(sq_cross) << 1;
    end

    // Add c back in
    assign zr_next = f_sat_add(r_tr_neg, r_tr_mag, r_cr_neg, r_cr_mag);
    assign zi_next = f_sat_add(r_ti_neg, r_ti_mag, r_ci_neg, r_ci_mag);

    // Sequencer next state
    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_max_steps = r_max_steps;
        n_sq_start  = 1'b0;
        n_cr_neg    = r_cr_neg;
        n_cr_mag    = r_cr_mag;
        n_ci_neg    = r_ci_neg;
        n_ci_mag    = r_ci_mag;
        n_zr_neg    = r_zr_neg;
        n_zr_mag    = r_zr_mag;
        n_zi_neg    = r_zi_neg;
        n_zi_mag    = r_zi_mag;
        n_tr_neg    = r_tr_neg;
        n_tr_mag    = r_tr_mag;
        n_ti_neg    = r_ti_neg;
        n_ti_mag    = r_ti_mag;

        if (i_cfg_wr_en) begin
            n_max_steps = i_cfg_wr_data;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_cr_neg = i_c_real[W-1];
                    n_cr_mag = cr_mag_in;
                    n_ci_neg = i_c_imag[W-1];
                    n_ci_mag = ci_mag_in;
                    n_zr_neg = 1'b0;
                    n_zr_mag = '0;
                    n_zi_neg = 1'b0;
                    n_zi_mag = '0;
                    n_n      = '0;
                    n_state  = S_LIMIT;
                end
            end
            S_LIMIT: begin
                if (r_n == r_max_steps) begin
                    n_state = S_DONE;
                end else begin
                    n_sq_start = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                if (sq_done) begin
                    n_state = S_TEST;
                end
            end
            S_TEST: begin
                if (escape) begin
                    n_state = S_DONE;
                end else begin
                    n_tr_neg = !re_ge;
                    n_tr_mag = diff_ext[F +: MW];
                    n_ti_neg = r_zr_neg ^ r_zi_neg;
                    n_ti_mag = cross_ext[F +: MW];
                    n_state  = S_UPD;
                end
            end
            S_UPD: begin
                n_zr_neg = zr_next[W];
                n_zr_mag = zr_next[W-1:0];
                n_zi_neg = zi_next[W];
                n_zi_mag = zi_next[W-1:0];
                n_n      = r_n + STEP_WIDTH'(1);
                n_state  = S_LIMIT;
            end
            S_DONE: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state, count and operands
    always_ff @(posedge i_clk) begin
        r_n      <= n_n;
        r_cr_neg <= n_cr_neg;
        r_cr_mag <= n_cr_mag;
        r_ci_neg <= n_ci_neg;
        r_ci_mag <= n_ci_mag;
        r_zr_neg <= n_zr_neg;
        r_zr_mag <= n_zr_mag;
        r_zi_neg <= n_zi_neg;
        r_zi_mag <= n_zi_mag;
        r_tr_neg <= n_tr_neg;
        r_tr_mag <= n_tr_mag;
        r_ti_neg <= n_ti_neg;
        r_ti_mag <= n_ti_mag;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_max_steps <= MAX_STEPS_RESET;
            r_sq_start  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_max_steps <= n_max_steps;
            r_sq_start  <= n_sq_start;
        end
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = (r_state == S_DONE);
    assign o_escape_count = r_n;

endmodule

`default_nettype wire

### dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import mbe_pkg::*;

    typedef logic signed [COORD_WIDTH_DEF-1:0] t_coord;
    typedef logic [STEP_WIDTH-1:0]             t_steps;

    typedef struct {
        t_coord re;
        t_coord im;
        t_steps count;
    } t_escape_result;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_STARVE
    } t_rx_mode;

    // Q4.60 landmarks
    localparam t_coord Q_ULP = t_coord'(1);
    localparam t_coord Q_ONE = t_coord'(1) << FRAC_BITS_DEF;
    localparam t_coord Q_MAX = {1'b0, {(COORD_WIDTH_DEF-1){1'b1}}};
    localparam t_coord Q_MIN = {1'b1, {(COORD_WIDTH_DEF-1){1'b0}}};

    // |z|^2 >= 4 at twice the fraction bits
    localparam logic [127:0] ESCAPE_RADIUS_SQ = 128'd1 << (2 * FRAC_BITS_DEF + 2);

    localparam int unsigned CYCLE_LIMIT  = 4_000_000;
    localparam int          SETTLE_TICKS = 40;

    logic   i_clk         = 1'b0;
    logic   i_rst_n       = 1'b0;
    logic   i_valid       = 1'b0;
    t_coord i_c_real      = '0;
    t_coord i_c_imag      = '0;
    logic   i_ready       = 1'b0;
    logic   i_cfg_wr_en   = 1'b0;
    t_steps i_cfg_wr_data = '0;
    logic   o_ready;
    logic   o_valid;
    t_steps o_escape_count;

    t_escape_result expected_counts[$];
    t_escape_result oldest;
    t_steps         step_limit   = MAX_STEPS_RESET;
    int             burst_left   = 0;
    int             mismatches   = 0;
    int unsigned    cycle_count  = 0;
    t_rx_mode       rx_mode      = RX_OPEN;
    int             rx_left      = 0;

    mandelbrot_escape_time i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_c_real       (i_c_real),
        .i_c_imag       (i_c_imag),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_escape_count (o_escape_count),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Saturate a widened sum back to the coordinate range
    function automatic t_coord clamp_coord(input logic signed [COORD_WIDTH_DEF+1:0] v);
        if (v > $signed({2'b00, Q_MAX})) begin
            return Q_MAX;
        end else if (v < $signed({2'b11, Q_MIN})) begin
            return Q_MIN;
        end
        return t_coord'(v);
    endfunction

    // Iterate z = z^2 + c from zero; count updates until |z| >= 2 or the limit
    function automatic t_steps escape_steps(input t_coord c_re, input t_coord c_im,
                                            input t_steps limit);
        t_coord                              z_re;
        t_coord                              z_im;
        logic [COORD_WIDTH_DEF-1:0]          m_re;
        logic [COORD_WIDTH_DEF-1:0]          m_im;
        logic [COORD_WIDTH_DEF-1:0]          m_cut;
        logic [127:0]                        sq_re;
        logic [127:0]                        sq_im;
        logic [127:0]                        prod_ri;
        logic signed [COORD_WIDTH_DEF+1:0]   w_re;
        logic signed [COORD_WIDTH_DEF+1:0]   w_im;
        int                                  n;
        z_re = '0;
        z_im = '0;
        for (n = 0; n < int'(limit); n++) begin
            m_re  = z_re[COORD_WIDTH_DEF-1] ? -z_re : z_re;
            m_im  = z_im[COORD_WIDTH_DEF-1] ? -z_im : z_im;
            sq_re = {64'd0, m_re} * {64'd0, m_re};
            sq_im = {64'd0, m_im} * {64'd0, m_im};
            if (sq_re + sq_im >= ESCAPE_RADIUS_SQ) begin
                break;
            end
            // real part: difference of squares, cut back toward zero
            if (sq_re >= sq_im) begin
                m_cut = COORD_WIDTH_DEF'((sq_re - sq_im) >> FRAC_BITS_DEF);
                w_re  = $signed({2'b00, m_cut});
            end else begin
                m_cut = COORD_WIDTH_DEF'((sq_im - sq_re) >> FRAC_BITS_DEF);
                w_re  = -$signed({2'b00, m_cut});
            end
            // imaginary part: doubled cross product, sign from the operands
            prod_ri = ({64'd0, m_re} * {64'd0, m_im}) << 1;
            m_cut   = COORD_WIDTH_DEF'(prod_ri >> FRAC_BITS_DEF);
            if (z_re[COORD_WIDTH_DEF-1] ^ z_im[COORD_WIDTH_DEF-1]) begin
                w_im = -$signed({2'b00, m_cut});
            end else begin
                w_im = $signed({2'b00, m_cut});
            end
            z_re = clamp_coord(w_re + c_re);
            z_im = clamp_coord(w_im + c_im);
        end
        return t_steps'(n);
    endfunction

    function automatic t_coord rand_below(input logic [COORD_WIDTH_DEF-1:0] span);
        logic [COORD_WIDTH_DEF-1:0] r;
        r = {$urandom, $urandom};
        return t_coord'(r % span);
    endfunction

    // Offer one point in bursts with random gaps; record its count on transfer
    task automatic send_point(input t_coord re, input t_coord im);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        i_c_real <= re;
        i_c_imag <= im;
        i_valid  <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        expected_counts.push_back('{re, im, escape_steps(re, im, step_limit)});
    endtask

    // Drop valid and hold until every pending count has come back
    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_counts.size() != 0) @(negedge i_clk);
    endtask

    task automatic set_step_limit(input t_steps limit);
        wait_drained();
        repeat (SETTLE_TICKS) @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= limit;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        step_limit = limit;
    endtask

    // Mostly points around the set; some raw words; far points for huge limits
    task automatic send_random_point(input bit far_only);
        t_coord re;
        t_coord im;
        if (far_only || $urandom_range(0, 3) == 0) begin
            re = {$urandom, $urandom};
            im = {$urandom, $urandom};
            if (far_only && re > -2 * Q_ONE && re < 2 * Q_ONE) begin
                re[COORD_WIDTH_DEF-2] = ~re[COORD_WIDTH_DEF-2];
            end
        end else begin
            re = rand_below(3 * Q_ONE) - (2 * Q_ONE + Q_ONE / 4);
            im = rand_below(3 * Q_ONE) - (Q_ONE + Q_ONE / 2);
        end
        send_point(re, im);
    endtask

    // Reset limit: one bounded point runs all 5000 steps
    task automatic test_reset_limit();
        send_point('0, '0);
        send_point(-2 * Q_ONE, '0);
        send_point(Q_MIN, Q_MIN);
        send_point(Q_MAX, Q_MAX);
        send_point('0, 2 * Q_ONE);
    endtask

    // Zero limit: no test is made, count is zero
    task automatic test_zero_limit();
        set_step_limit('0);
        send_point('0, '0);
        send_point(Q_MAX, Q_MIN);
    endtask

    task automatic test_one_step_limit();
        set_step_limit(t_steps'(1));
        send_point('0, '0);
        send_point(-2 * Q_ONE, '0);
        send_point(2 * Q_ONE - Q_ULP, '0);
    endtask

    // Largest limit: only points that escape quickly
    task automatic test_full_limit();
        set_step_limit('1);
        send_point(-2 * Q_ONE, '0);
        send_point(2 * Q_ONE - Q_ULP, '0);
        send_point(Q_ONE / 2, Q_ONE / 2);
        send_point(Q_ONE / 4 + Q_ONE / 100, '0);
    endtask

    // Escape boundary, truncation of negative parts, tiny and patterned c
    task automatic test_boundary_points();
        set_step_limit(t_steps'(64));
        send_point(-2 * Q_ONE + Q_ULP, '0);
        send_point(-Q_ULP, -Q_ULP);
        send_point(Q_ULP, Q_ULP);
        send_point(-(Q_ONE / 2 + Q_ONE / 4), '0);
        send_point(t_coord'(64'h5555_5555_5555_5555), t_coord'(64'hAAAA_AAAA_AAAA_AAAA));
    endtask

    task automatic test_random_points();
        int     phase;
        int     k;
        t_steps limit;
        for (phase = 0; phase < 5; phase++) begin
            case (phase)
                0:       limit = t_steps'($urandom_range(1, 16));
                1:       limit = t_steps'($urandom_range(17, 128));
                2:       limit = t_steps'($urandom_range(129, 400));
                3:       limit = '1;
                default: limit = t_steps'($urandom_range(1, 64));
            endcase
            set_step_limit(limit);
            for (k = 0; k < 24; k++) begin
                // hold the sender once until the block has emptied
                if (phase == 1 && k == 12) begin
                    wait_drained();
                end
                send_random_point(phase == 3);
            end
        end
    endtask

    // Receiver: switch stall pattern every so often
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
            rx_left <= $urandom_range(16, 200);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_OPEN:   i_ready <= 1'b1;
            RX_COIN:   i_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: i_ready <= ($urandom_range(0, 3) == 0);
            default:   i_ready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    // Compare each transferred count with the oldest pending point
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_counts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("count %0d transferred with no point pending", o_escape_count);
                end
            end else begin
                oldest = expected_counts.pop_front();
                if (o_escape_count !== oldest.count) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("point (%h, %h): expected count %0d, got %0d",
                                 oldest.re, oldest.im, oldest.count, o_escape_count);
                    end
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_limit();
        test_zero_limit();
        test_one_step_limit();
        test_full_limit();
        test_boundary_points();
        test_random_points();

        wait_drained();
        repeat (SETTLE_TICKS) @(negedge i_clk);
        if (mismatches == 0 && expected_counts.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### filelist.f
sv/mbe_pkg.sv
sv/mbe_sq_unit.sv
sv/mandelbrot_escape_time.sv
dv/tb.sv
